// ----- hw/rtl/flvtf_pkg.sv -----
package flvtf_pkg;

  // item kinds on the input channel
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_DATA  = 1'b1;

  // tag type codes
  localparam logic [7:0] TAG_TYPE_AUDIO = 8'h08;
  localparam logic [7:0] TAG_TYPE_VIDEO = 8'h09;

  // codec body bytes
  localparam logic [7:0] VIDEO_KEY_BYTE   = 8'h17;
  localparam logic [7:0] VIDEO_INTER_BYTE = 8'h27;
  localparam logic [7:0] AAC_BODY_BYTE    = 8'hAF;
  localparam logic [7:0] AAC_RAW_BYTE     = 8'h01;
  localparam logic [6:0] EXT_TS_MASK      = 7'h7F;

  // avc packet type byte
  localparam logic [7:0] AVC_SEQ_HEADER = 8'h00;
  localparam logic [7:0] AVC_NALU       = 8'h01;

  // lengths
  localparam int TAG_HEADER_LEN = 11;
  localparam int VIDEO_BODY_LEN = 5;
  localparam int AUDIO_BODY_LEN = 2;
  localparam int TRAILER_LEN    = 4;
  localparam int BURST_DEPTH    = 16;
  localparam int BURST_CNT_W    = $clog2(BURST_DEPTH + 1);
  localparam int TAG_LEN_W      = 25;

  typedef struct packed {
    logic        kind;
    logic        is_video;
    logic        keyframe;
    logic        seq_hdr;
    logic [23:0] payload_size;
    logic [31:0] timestamp;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

endpackage

// ----- hw/rtl/flv_media_tag_framer_top.sv -----
// FLV tag framer for H.264 video and AAC audio packets.
// Input channel (in_valid / in_stall / in_data): a start item describes a
// packet (kind, size, timestamp, keyframe and sequence-header marks), then
// one data item per payload byte follows. Output channel (out_valid /
// out_stall / out_data) carries the tag byte stream, one byte per transfer,
// with last set on the final byte of the previous-tag-size trailer.
// Latency: the first byte of an item's output is presented the cycle after
// the item is accepted.
// A payload byte yields one output byte; the last payload byte yields five
// (byte plus trailer); a start item yields 16 (video), 13 (audio) or 11
// (audio sequence header) bytes. These fill the 16-byte output shift
// buffer, which drains one byte per cycle while out_stall is low and takes
// a new item in the same cycle that its final byte is transferred.
// A zero-size start or a data item with no open tag produces no output.
// Reset clears the buffer count and the open-tag state; nothing is emitted.
// When the receiver stalls, the current byte holds; in_stall is high while the
// buffer holds more than one byte, and also with one byte while stalled.
module flv_media_tag_framer_top
  import flvtf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // packet state
  logic [23:0]          bytes_left;
  logic [TAG_LEN_W-1:0] tag_len_m1;
  logic                 in_packet;

  // output shift buffer
  logic [7:0]             burst [BURST_DEPTH];
  logic [BURST_CNT_W-1:0] burst_cnt;
  logic                   burst_last;

  logic                   in_xfer;
  logic                   out_xfer;
  logic [7:0]             new_bytes [BURST_DEPTH];
  logic [BURST_CNT_W-1:0] new_cnt;
  logic                   new_last;
  logic [2:0]             body_len;
  logic [23:0]            data_size;
  logic [TAG_LEN_W-1:0]   tag_len_next;
  logic [23:0]            bytes_left_next;
  logic [TAG_LEN_W-1:0]   tag_len_m1_next;
  logic                   in_packet_next;

  // handshakes
  assign out_valid = (burst_cnt != '0);
  assign out_xfer  = out_valid && !out_stall;
  assign in_stall  = (burst_cnt > BURST_CNT_W'(1)) ||
                     ((burst_cnt == BURST_CNT_W'(1)) && out_stall);
  assign in_xfer   = in_valid && !in_stall;

  assign out_data.out_byte = burst[0];
  assign out_data.last     = burst_last && (burst_cnt == BURST_CNT_W'(1));

  // body length and derived sizes of a start item
  always_comb begin
    if (in_data.is_video) begin
      body_len = 3'(VIDEO_BODY_LEN);
    end else if (in_data.seq_hdr) begin
      body_len = 3'd0;
    end else begin
      body_len = 3'(AUDIO_BODY_LEN);
    end
    data_size    = in_data.payload_size + 24'(body_len);
    tag_len_next = {1'b0, in_data.payload_size} + TAG_LEN_W'(TAG_HEADER_LEN - 1)
                   + TAG_LEN_W'(body_len);
  end

  // build the output burst for the incoming item
  always_comb begin
    for (int i = 0; i < BURST_DEPTH; i++) begin
      new_bytes[i] = 8'h00;
    end
    new_cnt         = '0;
    new_last        = 1'b0;
    bytes_left_next = bytes_left;
    tag_len_m1_next = tag_len_m1;
    in_packet_next  = in_packet;
    if (in_data.kind == KIND_START) begin
      if (in_data.payload_size == 24'd0) begin
        in_packet_next  = 1'b0;
        bytes_left_next = 24'd0;
      end else begin
        new_bytes[0] = in_data.is_video ? TAG_TYPE_VIDEO : TAG_TYPE_AUDIO;
        new_bytes[1] = data_size[23:16];
        new_bytes[2] = data_size[15:8];
        new_bytes[3] = data_size[7:0];
        new_bytes[4] = in_data.timestamp[23:16];
        new_bytes[5] = in_data.timestamp[15:8];
        new_bytes[6] = in_data.timestamp[7:0];
        new_bytes[7] = {1'b0, in_data.timestamp[30:24] & EXT_TS_MASK};
        if (in_data.is_video) begin
          new_bytes[11] = in_data.keyframe ? VIDEO_KEY_BYTE : VIDEO_INTER_BYTE;
          new_bytes[12] = in_data.seq_hdr ? AVC_SEQ_HEADER : AVC_NALU;
        end else if (!in_data.seq_hdr) begin
          new_bytes[11] = AAC_BODY_BYTE;
          new_bytes[12] = AAC_RAW_BYTE;
        end
        new_cnt         = BURST_CNT_W'(TAG_HEADER_LEN) + BURST_CNT_W'(body_len);
        bytes_left_next = in_data.payload_size;
        tag_len_m1_next = tag_len_next;
        in_packet_next  = 1'b1;
      end
    end else if (in_packet && (bytes_left != 24'd0)) begin
      new_bytes[0]    = in_data.data_byte;
      new_cnt         = BURST_CNT_W'(1);
      bytes_left_next = bytes_left - 24'd1;
      // trailer: tag length minus one, big endian
      if (bytes_left == 24'd1) begin
        new_bytes[1]   = {7'd0, tag_len_m1[24]};
        new_bytes[2]   = tag_len_m1[23:16];
        new_bytes[3]   = tag_len_m1[15:8];
        new_bytes[4]   = tag_len_m1[7:0];
        new_cnt        = BURST_CNT_W'(1 + TRAILER_LEN);
        new_last       = 1'b1;
        in_packet_next = 1'b0;
      end
    end
  end

  // packet state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left <= '0;
      tag_len_m1 <= '0;
      in_packet  <= 1'b0;
    end else if (in_xfer) begin
      bytes_left <= bytes_left_next;
      tag_len_m1 <= tag_len_m1_next;
      in_packet  <= in_packet_next;
    end
  end

  // output buffer control
  always_ff @(posedge clk) begin
    if (rst) begin
      burst_cnt  <= '0;
      burst_last <= 1'b0;
    end else if (in_xfer) begin
      burst_cnt  <= new_cnt;
      burst_last <= new_last;
    end else if (out_xfer) begin
      burst_cnt <= burst_cnt - BURST_CNT_W'(1);
    end
  end

  // output buffer payload: load or shift toward the head
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      for (int i = 0; i < BURST_DEPTH; i++) begin
        burst[i] <= new_bytes[i];
      end
    end else if (out_xfer) begin
      for (int i = 0; i < BURST_DEPTH - 1; i++) begin
        burst[i] <= burst[i + 1];
      end
    end
  end

  // an open tag always expects at least one more payload byte
  a_open_has_bytes : assert property (@(posedge clk) disable iff (rst)
    in_packet |-> (bytes_left != 24'd0))
    else $error("open tag with no bytes left");

  // the trailer's final byte leaves only after the tag was closed
  a_last_closes_tag : assert property (@(posedge clk) disable iff (rst)
    (out_xfer && out_data.last) |-> !in_packet)
    else $error("last byte sent while tag still open");

  // a nonzero start loads a full header burst
  a_start_burst : assert property (@(posedge clk) disable iff (rst)
    (in_xfer && (in_data.kind == KIND_START) && (in_data.payload_size != 24'd0))
    |=> (burst_cnt >= BURST_CNT_W'(TAG_HEADER_LEN)) && in_packet)
    else $error("start item did not load a header burst");

  // an accepted payload byte yields the byte alone or the byte and trailer
  a_data_burst : assert property (@(posedge clk) disable iff (rst)
    (in_xfer && (in_data.kind == KIND_DATA) && in_packet)
    |=> (burst_cnt == BURST_CNT_W'(1)) || (burst_cnt == BURST_CNT_W'(1 + TRAILER_LEN)))
    else $error("payload byte produced a wrong burst length");

endmodule
